### src/pd_pkg.sv
// shared types, constants and helpers for the percent decoder
package pd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // escape tracking state
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PCT   = 2'd1,
    HOLD_DIGIT = 2'd2
  } hold_t;

  // one input's worth of output bytes, emitted in order data[0] first
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

### src/pd_front.sv
// front end: tracks open escapes and turns each input byte into a command
module pd_front import pd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  hold_t      hold;
  hold_t      hold_next;
  logic [7:0] held_char;
  logic [7:0] held_char_next;
  hex_t       hx;
  hex_t       hx_held;
  logic       accept;
  logic       opens;

  assign hx       = hex_decode(in_byte);
  assign hx_held  = hex_decode(held_char);
  assign opens    = (in_byte == PCT_CHAR) && !in_last;
  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  // next escape state
  always_comb begin
    hold_next      = HOLD_NONE;
    held_char_next = held_char;
    case (hold)
      HOLD_PCT: begin
        if (hx.ok && !in_last) begin
          held_char_next = in_byte;
          hold_next      = HOLD_DIGIT;
        end else if (!hx.ok && opens) begin
          hold_next = HOLD_PCT;
        end
      end
      HOLD_DIGIT: begin
        if (!hx.ok && opens) begin
          hold_next = HOLD_PCT;
        end
      end
      default: begin
        if (opens) begin
          hold_next = HOLD_PCT;
        end
      end
    endcase
  end

  // command built from held characters plus the new one
  always_comb begin
    logic fresh;
    cmd.cnt  = 2'd0;
    cmd.data = '0;
    cmd.last = in_last;
    fresh    = 1'b0;
    case (hold)
      HOLD_PCT: begin
        if (hx.ok && in_last) begin
          cmd.data[0] = PCT_CHAR;
          cmd.data[1] = in_byte;
          cmd.cnt     = 2'd2;
        end else if (!hx.ok) begin
          cmd.data[0] = PCT_CHAR;
          cmd.cnt     = 2'd1;
          fresh       = 1'b1;
        end
      end
      HOLD_DIGIT: begin
        if (hx.ok) begin
          cmd.data[0] = {hx_held.val, hx.val};
          cmd.cnt     = 2'd1;
        end else begin
          cmd.data[0] = PCT_CHAR;
          cmd.data[1] = held_char;
          cmd.cnt     = 2'd2;
          fresh       = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase
    if (fresh && !opens) begin
      cmd.data[cmd.cnt] = in_byte;
      cmd.cnt           = cmd.cnt + 2'd1;
    end
  end

  // inputs that only open or extend an escape produce nothing
  assign cmd_valid = in_valid && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold      <= HOLD_NONE;
      held_char <= 8'd0;
    end else if (accept) begin
      hold      <= hold_next;
      held_char <= held_char_next;
    end
  end

endmodule

### src/pd_queue.sv
// small command queue between front and back
module pd_queue import pd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### src/pd_back.sv
// back end: sends the bytes of the head command one per cycle while out_ready is high
module pd_back import pd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end,
  input  logic       out_ready
);

  logic [1:0] idx;
  logic       fire;

  assign out_valid  = cmd_valid;
  assign out_byte   = cmd.data[idx];
  assign run_last   = (idx == cmd.cnt - 2'd1);
  assign string_end = run_last && cmd.last;
  assign fire       = out_valid && out_ready;
  assign cmd_pop    = fire && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

### src/percent_decoder.sv
// top level of the streaming url percent decoder
//
// input stream (s_*): one encoded character per request, s_tlast on the
//   final character of a string; accepted when s_tvalid and s_tready are high
// output stream (m_*): one decoded character per request, m_tuser marks the
//   last character produced by an input, m_tlast the last of the string
// "%hh" in either case becomes one byte; a broken escape sends '%' and the
//   held digit literally and the breaking character is handled afresh
// an input gives zero to three output characters; the front end classifies
//   it in the accept cycle and drops a command into a two-entry queue, the
//   back end drains one character per cycle while m_tready is high
// a command is registered in the queue when its input is accepted and is
//   sent once at the head; throughput is one input per cycle while inputs
//   give at most one character and m_tready is high; longer ones hold the head
// reset: clears any open escape and empties the queue
// receiver stall: output holds; the queue fills and then s_tready drops
module percent_decoder import pd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // string_end
);

  logic front_valid;
  cmd_t front_cmd;
  logic front_ready;
  logic head_valid;
  cmd_t head_cmd;
  logic head_pop;

  // escape tracking and command build
  pd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  // decouples classification from output pacing
  pd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_cmd   (front_cmd),
    .wr_ready (front_ready),
    .rd_valid (head_valid),
    .rd_cmd   (head_cmd),
    .rd_pop   (head_pop)
  );

  // serializes each command onto the output stream
  pd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (head_pop),
    .out_valid  (m_tvalid),
    .out_byte   (m_tdata),
    .run_last   (m_tuser),
    .string_end (m_tlast),
    .out_ready  (m_tready)
  );

endmodule
